// ----- src/mctt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_pkg
// Shared types and command codes for the multi-channel tick timer.
// ----------------------------------------------------------------------------
package mctt_pkg;

    // Command codes carried in the command field
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_ALLOCATE = 3'd1;
    localparam logic [2:0] CMD_SET      = 3'd2;
    localparam logic [2:0] CMD_START    = 3'd3;
    localparam logic [2:0] CMD_STOP     = 3'd4;

    // Input beat: one command
    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  channel;
        logic [31:0] reload_value;
        logic        one_shot;
    } cmd_beat_t;

    // Output beat: one response
    typedef struct packed {
        logic       ok;
        logic [2:0] channel_given;
        logic [7:0] fired_mask;
    } rsp_beat_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DONE
    } seq_state_t;

endpackage

// ----- src/mctt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mctt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    clk,
    we,
    waddr,
    wdata,
    raddr,
    rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             clk;
    input  logic             we;
    input  logic [AW-1:0]    waddr;
    input  logic [WIDTH-1:0] wdata;
    input  logic [AW-1:0]    raddr;
    output logic [WIDTH-1:0] rdata;

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- src/multi_channel_tick_timer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_tick_timer
// Bank of tick timers driven by one command per beat; a tick walks the
// allocated channels with a single shared incrementer and comparator.
// ----------------------------------------------------------------------------
//
//  port group | dir | handshake          | payload
//  -----------+-----+--------------------+------------------------------
//  cmd        | in  | cmd_valid/cmd_stall | cmd_beat_t (command, channel,
//             |     |                    |   reload_value, one_shot)
//  rsp        | out | rsp_valid/rsp_stall | rsp_beat_t (ok, channel_given,
//             |     |                    |   fired_mask)
//
//  Allocate, set, start, stop and unknown codes: response in the cycle after accept.
//  Tick: each allocated channel passes a READ state (count/reload RAM read) and an
//  UPDATE state (shared increment-and-compare); ST_DONE then issues the response.
//  Reset is immediate: per-entry valid bits make unwritten counts and reloads
//  read as zero, so there is no clearing pass.
//  A stalled response blocks new commands; a response being taken does not.
//
module multi_channel_tick_timer #(
    parameter int CHANNELS = 8
) (
    clk,
    rst_n,
    cmd_valid,
    cmd_stall,
    cmd,
    rsp_valid,
    rsp_stall,
    rsp
);
    import mctt_pkg::*;

    localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNTW = $clog2(CHANNELS + 1);

    input  logic                clk;
    input  logic                rst_n;
    input  logic                cmd_valid;
    output logic                cmd_stall;
    input  mctt_pkg::cmd_beat_t cmd;
    output logic                rsp_valid;
    input  logic                rsp_stall;
    output mctt_pkg::rsp_beat_t rsp;

    // Control state
    seq_state_t         state_reg, state_next;
    logic [CNTW-1:0]    alloc_reg, alloc_next;
    logic [IDXW-1:0]    idx_reg, idx_next;
    logic [7:0]         mask_reg, mask_next;
    logic [CHANNELS-1:0] enabled_reg, enabled_next;
    logic [CHANNELS-1:0] oneshot_reg, oneshot_next;
    logic [CHANNELS-1:0] cnt_vld_reg, cnt_vld_next;
    logic [CHANNELS-1:0] rld_vld_reg, rld_vld_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_beat_t          rsp_reg, rsp_next;

    // RAM ports
    logic               cnt_we;
    logic [IDXW-1:0]    cnt_waddr;
    logic [31:0]        cnt_wdata;
    logic [31:0]        cnt_rdata;
    logic               rld_we;
    logic [IDXW-1:0]    rld_waddr;
    logic [31:0]        rld_wdata;
    logic [31:0]        rld_rdata;

    logic               out_free;
    logic               accept;
    logic               in_range;
    logic [IDXW-1:0]    ch_idx;
    logic               last_ch;

    mctt_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (idx_reg),
        .rdata (cnt_rdata)
    );

    mctt_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_reload_ram (
        .clk   (clk),
        .we    (rld_we),
        .waddr (rld_waddr),
        .wdata (rld_wdata),
        .raddr (idx_reg),
        .rdata (rld_rdata)
    );

    // Handshake
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = !((state_reg == ST_IDLE) && out_free);
    assign accept    = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Channel decode
    assign in_range = {1'b0, cmd.channel} < 9'(CHANNELS);
    assign ch_idx   = cmd.channel[IDXW-1:0];
    assign last_ch  = (CNTW'(idx_reg) + CNTW'(1)) == alloc_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.command == CMD_TICK))
                begin
                    state_next = (alloc_reg == '0) ? ST_DONE : ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = last_ch ? ST_DONE : ST_READ;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        logic [31:0] cnt_cur;
        logic [31:0] rld_cur;
        logic [31:0] sum;
        logic        fire;
        logic [6:0]  idx_ext;

        alloc_next     = alloc_reg;
        idx_next       = idx_reg;
        mask_next      = mask_reg;
        enabled_next   = enabled_reg;
        oneshot_next   = oneshot_reg;
        cnt_vld_next   = cnt_vld_reg;
        rld_vld_next   = rld_vld_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cnt_we         = 1'b0;
        cnt_waddr      = idx_reg;
        cnt_wdata      = '0;
        rld_we         = 1'b0;
        rld_waddr      = ch_idx;
        rld_wdata      = cmd.reload_value;

        // Shared increment-and-compare unit
        cnt_cur = cnt_vld_reg[idx_reg] ? cnt_rdata : 32'd0;
        rld_cur = rld_vld_reg[idx_reg] ? rld_rdata : 32'd0;
        sum     = cnt_cur + 32'd1;
        fire    = sum >= rld_cur;
        idx_ext = 7'(idx_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_next = '{ok: 1'b0, channel_given: 3'd0, fired_mask: 8'd0};
                    unique case (cmd.command)
                        CMD_TICK:
                        begin
                            idx_next  = '0;
                            mask_next = '0;
                        end
                        CMD_ALLOCATE:
                        begin
                            if (alloc_reg < CNTW'(CHANNELS))
                            begin
                                rsp_next.ok            = 1'b1;
                                rsp_next.channel_given = 3'(alloc_reg);
                                alloc_next             = alloc_reg + CNTW'(1);
                            end
                        end
                        CMD_SET:
                        begin
                            if (in_range)
                            begin
                                rsp_next.ok          = 1'b1;
                                oneshot_next[ch_idx] = cmd.one_shot;
                                enabled_next[ch_idx] = 1'b0;
                                cnt_we               = 1'b1;
                                cnt_waddr            = ch_idx;
                                cnt_vld_next[ch_idx] = 1'b1;
                                rld_we               = 1'b1;
                                rld_vld_next[ch_idx] = 1'b1;
                            end
                        end
                        CMD_START:
                        begin
                            if (in_range)
                            begin
                                rsp_next.ok          = 1'b1;
                                enabled_next[ch_idx] = 1'b1;
                                cnt_we               = 1'b1;
                                cnt_waddr            = ch_idx;
                                cnt_vld_next[ch_idx] = 1'b1;
                            end
                        end
                        CMD_STOP:
                        begin
                            if (in_range)
                            begin
                                rsp_next.ok          = 1'b1;
                                enabled_next[ch_idx] = 1'b0;
                            end
                        end
                        default:
                        begin
                            rsp_next.ok = 1'b0;
                        end
                    endcase
                    if (cmd.command != CMD_TICK)
                    begin
                        rsp_valid_next = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                // RAM read of count and reload in flight
            end
            ST_UPDATE:
            begin
                if (enabled_reg[idx_reg])
                begin
                    cnt_we                = 1'b1;
                    cnt_waddr             = idx_reg;
                    cnt_wdata             = fire ? 32'd0 : sum;
                    cnt_vld_next[idx_reg] = 1'b1;
                    if (fire)
                    begin
                        if (idx_ext < 7'd8)
                        begin
                            mask_next[idx_ext[2:0]] = 1'b1;
                        end
                        if (oneshot_reg[idx_reg])
                        begin
                            enabled_next[idx_reg] = 1'b0;
                        end
                    end
                end
                if (!last_ch)
                begin
                    idx_next = idx_reg + IDXW'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_next       = '{ok: 1'b1, channel_given: 3'd0, fired_mask: mask_reg};
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            alloc_reg     <= '0;
            enabled_reg   <= '0;
            oneshot_reg   <= '0;
            cnt_vld_reg   <= '0;
            rld_vld_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alloc_reg     <= alloc_next;
            enabled_reg   <= enabled_next;
            oneshot_reg   <= oneshot_next;
            cnt_vld_reg   <= cnt_vld_next;
            rld_vld_reg   <= rld_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        mask_reg <= mask_next;
        rsp_reg  <= rsp_next;
    end

endmodule

// ----- src/mctt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_checker
// Port-level checks for the tick timer, bound to the top level.
// ----------------------------------------------------------------------------
module mctt_checker (
    clk,
    rst_n,
    cmd_valid,
    cmd_stall,
    cmd,
    rsp_valid,
    rsp_stall,
    rsp
);
    import mctt_pkg::*;

    input logic                clk;
    input logic                rst_n;
    input logic                cmd_valid;
    input logic                cmd_stall;
    input mctt_pkg::cmd_beat_t cmd;
    input logic                rsp_valid;
    input logic                rsp_stall;
    input mctt_pkg::rsp_beat_t rsp;

    // Stalled response beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

    // No new command while a response is stuck
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> cmd_stall)
    else $error("command taken while response stalled");

    // Non-tick commands answer next cycle with an empty fired mask
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd.command != CMD_TICK)
        |=> rsp_valid && (rsp.fired_mask == 8'd0))
    else $error("non-tick response missing or has fired bits");

    // Unknown codes fail with an empty response
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd.command != CMD_TICK)
        && (cmd.command != CMD_ALLOCATE) && (cmd.command != CMD_SET)
        && (cmd.command != CMD_START) && (cmd.command != CMD_STOP)
        |=> !rsp.ok && (rsp.channel_given == 3'd0))
    else $error("unknown command not rejected");

endmodule

bind multi_channel_tick_timer mctt_checker u_mctt_checker (.*);

// ----- tb/multi_channel_tick_timer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_tick_timer_tb
// Self-checking bench for the tick timer bank. A driver pushes command beats
// from a pending queue, a cycle-free predictor computes each response, and
// a monitor checks every response beat in order, under varying idle and
// stall pressure.
// ----------------------------------------------------------------------------
module multi_channel_tick_timer_tb;

    import mctt_pkg::*;

    localparam int NCH        = 8;
    localparam int NCH_W      = $clog2(NCH);
    localparam int IDLE_LIMIT = 4000;   // cycles without any beat
    localparam int HOLD_LEN   = 300;    // long receiver hold-off
    localparam int TAIL_LEN   = 40;     // settle time after the last response

    // Codes outside the command set, rejected by the block
    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_beat_t cmd_beat  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_beat_t rsp_beat;

    // Stimulus control, written at the falling edge
    int        idle_pct  = 0;
    int        stall_pct = 0;
    int        hold_req  = 0;

    cmd_beat_t cmd_pending_q[$];
    rsp_beat_t rsp_expect_q[$];

    // Predicted timer state
    logic        run_en  [NCH];
    logic        shot_md [NCH];
    logic [31:0] tick_cnt[NCH];
    logic [31:0] reload  [NCH];
    int          alloc_cnt;

    int n_fail     = 0;
    int n_cmds     = 0;
    int n_ticks    = 0;
    int n_expired  = 0;
    int n_rejected = 0;
    int n_rsp      = 0;

    multi_channel_tick_timer #(
        .CHANNELS(NCH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd_beat),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp_beat)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < NCH; i++)
        begin
            run_en[i]   = 1'b0;
            shot_md[i]  = 1'b0;
            tick_cnt[i] = '0;
            reload[i]   = '0;
        end
        alloc_cnt = 0;
    end

    task automatic flag_mismatch(input string msg);
        $display("tb: mismatch: %s", msg);
        n_fail++;
    endtask

    // Advance the timer bank by one command and return its response
    function automatic rsp_beat_t timer_step(input cmd_beat_t c);
        rsp_beat_t        r;
        logic             in_range;
        logic [NCH_W-1:0] ci;
        r        = '0;
        in_range = (c.channel < NCH);
        ci       = c.channel[NCH_W-1:0];
        case (c.command)
            CMD_TICK:
            begin
                r.ok = 1'b1;
                for (int i = 0; i < NCH; i++)
                begin
                    if (i < alloc_cnt && run_en[i])
                    begin
                        tick_cnt[i] = tick_cnt[i] + 32'd1;
                        if (tick_cnt[i] >= reload[i])
                        begin
                            r.fired_mask[i] = 1'b1;
                            tick_cnt[i]     = '0;
                            if (shot_md[i])
                                run_en[i] = 1'b0;
                        end
                    end
                end
            end
            CMD_ALLOCATE:
            begin
                if (alloc_cnt < NCH)
                begin
                    r.channel_given = alloc_cnt[2:0];
                    r.ok            = 1'b1;
                    alloc_cnt++;
                end
            end
            CMD_SET:
            begin
                if (in_range)
                begin
                    shot_md[ci]  = c.one_shot;
                    tick_cnt[ci] = '0;
                    reload[ci]   = c.reload_value;
                    run_en[ci]   = 1'b0;
                    r.ok         = 1'b1;
                end
            end
            CMD_START:
            begin
                if (in_range)
                begin
                    tick_cnt[ci] = '0;
                    run_en[ci]   = 1'b1;
                    r.ok         = 1'b1;
                end
            end
            CMD_STOP:
            begin
                if (in_range)
                begin
                    run_en[ci] = 1'b0;
                    r.ok       = 1'b1;
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    // Driver: offer pending beats, hold a stalled beat steady
    always @(posedge clk or negedge rst_n)
    begin
        cmd_beat_t nxt;
        rsp_beat_t exp_rsp;
        logic      busy;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd_beat  <= '0;
        end
        else
        begin
            busy = cmd_valid;
            if (cmd_valid && !cmd_stall)
            begin
                exp_rsp = timer_step(cmd_beat);
                rsp_expect_q.push_back(exp_rsp);
                n_cmds++;
                if (cmd_beat.command == CMD_TICK)
                begin
                    n_ticks++;
                    n_expired += $countones(exp_rsp.fired_mask);
                end
                if (!exp_rsp.ok)
                    n_rejected++;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (cmd_pending_q.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    nxt = cmd_pending_q.pop_front();
                    cmd_beat  <= nxt;
                    cmd_valid <= 1'b1;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check responses in order and drive the stall
    always @(posedge clk or negedge rst_n)
    begin
        rsp_beat_t exp_rsp;
        int        hold_left;
        int        hold_seen;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_expect_q.size() == 0)
                begin
                    flag_mismatch($sformatf("response %0d with nothing expected", n_rsp));
                end
                else
                begin
                    exp_rsp = rsp_expect_q.pop_front();
                    if (rsp_beat.ok !== exp_rsp.ok)
                        flag_mismatch($sformatf("response %0d ok got %0b exp %0b",
                                                n_rsp, rsp_beat.ok, exp_rsp.ok));
                    if (rsp_beat.channel_given !== exp_rsp.channel_given)
                        flag_mismatch($sformatf("response %0d channel_given got %0d exp %0d",
                                                n_rsp, rsp_beat.channel_given,
                                                exp_rsp.channel_given));
                    if (rsp_beat.fired_mask !== exp_rsp.fired_mask)
                        flag_mismatch($sformatf("response %0d fired_mask got %h exp %h",
                                                n_rsp, rsp_beat.fired_mask,
                                                exp_rsp.fired_mask));
                end
                n_rsp++;
            end
            // long hold-off on request, otherwise random stalls
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        int quiet;
        if (!rst_n)
        begin
            quiet = 0;
        end
        else
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("tb: no beat for %0d cycles", quiet);
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic push_cmd(input logic [2:0] op, input logic [7:0] ch,
                            input logic [31:0] rl, input logic sh);
        cmd_beat_t b;
        b.command      = op;
        b.channel      = ch;
        b.reload_value = rl;
        b.one_shot     = sh;
        cmd_pending_q.push_back(b);
    endtask

    // Mostly short reloads so channels expire often; now and then any value
    function automatic logic [31:0] pick_reload();
        if ($urandom_range(99) < 85)
            return $urandom_range(6, 0);
        return $urandom;
    endfunction

    task automatic queue_directed();
        push_cmd(CMD_TICK, 8'd0, 32'd0, 1'b0);            // nothing allocated
        push_cmd(CMD_SET, 8'd0, 32'd0, 1'b0);             // zero reload, periodic
        push_cmd(CMD_START, 8'd0, 32'hFFFF_FFFF, 1'b1);
        push_cmd(CMD_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b1);   // enabled but unallocated
        push_cmd(CMD_ALLOCATE, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        push_cmd(CMD_TICK, 8'd0, 32'd0, 1'b0);            // fires every tick
        push_cmd(CMD_SET, 8'd1, 32'd2, 1'b1);             // one-shot after two
        push_cmd(CMD_START, 8'd1, 32'd0, 1'b0);
        push_cmd(CMD_ALLOCATE, 8'd0, 32'd0, 1'b0);
        push_cmd(CMD_ALLOCATE, 8'd0, 32'd0, 1'b0);
        push_cmd(CMD_TICK, 8'd0, 32'd0, 1'b0);
        push_cmd(CMD_TICK, 8'd0, 32'd0, 1'b0);            // channel 1 expires
        push_cmd(CMD_TICK, 8'd0, 32'd0, 1'b0);            // and stays off
        push_cmd(CMD_STOP, 8'd0, 32'd0, 1'b0);
        push_cmd(CMD_TICK, 8'd0, 32'd0, 1'b0);
        push_cmd(CMD_SET, 8'hFF, 32'd1, 1'b1);            // out of range
        push_cmd(CMD_START, 8'd8, 32'd1, 1'b0);
        push_cmd(CMD_STOP, 8'h80, 32'd1, 1'b0);
        push_cmd(CMD_UNUSED_FIRST, 8'd0, 32'hFFFF_FFFF, 1'b1);
        push_cmd(CMD_UNUSED_FIRST + 3'd1, 8'd1, 32'hA5A5_5A5A, 1'b0);
        push_cmd(CMD_UNUSED_LAST, 8'd2, 32'd0, 1'b1);
        push_cmd(CMD_SET, 8'd2, 32'hFFFF_FFFF, 1'b0);     // longest reload
        push_cmd(CMD_START, 8'd2, 32'd0, 1'b0);
        repeat (6) push_cmd(CMD_ALLOCATE, 8'd0, 32'd0, 1'b0);  // last one fails
        push_cmd(CMD_TICK, 8'd0, 32'd0, 1'b0);
    endtask

    // Mostly set/start/tick bursts with random content, plus noise
    task automatic queue_random_work(input int n);
        int          added;
        int          kind;
        int          ticks;
        logic [7:0]  ch;
        logic [2:0]  op;
        added = 0;
        while (added < n)
        begin
            kind = $urandom_range(99);
            if (kind < 55)
            begin
                ch    = 8'($urandom_range(NCH - 1));
                ticks = $urandom_range(8, 1);
                push_cmd(CMD_SET, ch, pick_reload(), 1'($urandom_range(1)));
                push_cmd(CMD_START, ch, $urandom, 1'($urandom_range(1)));
                repeat (ticks) push_cmd(CMD_TICK, 8'($urandom_range(255)), $urandom,
                                        1'($urandom_range(1)));
                added += 2 + ticks;
            end
            else
            begin
                if (kind < 72)
                    op = CMD_TICK;
                else if (kind < 80)
                    op = CMD_STOP;
                else if (kind < 85)
                    op = CMD_ALLOCATE;
                else if (kind < 90)
                    op = CMD_START;
                else if (kind < 95)
                    op = CMD_SET;
                else
                    op = 3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
                // a fifth of the addressed commands miss the bank
                if ($urandom_range(4) == 0)
                    ch = 8'($urandom_range(255, NCH));
                else
                    ch = 8'($urandom_range(NCH - 1));
                push_cmd(op, ch, (op == CMD_SET) ? pick_reload() : $urandom,
                         1'($urandom_range(1)));
                added++;
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_pending_q.size() != 0 || cmd_valid || rsp_expect_q.size() != 0);
    endtask

    // Stimulus sequence and end of run
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_directed();
        wait_drained();

        // no idling
        idle_pct  = 0;
        stall_pct = 0;
        queue_random_work(340);
        wait_drained();

        // receiver holds off while the sender keeps offering
        hold_req++;
        queue_random_work(60);
        wait_drained();

        // sender mostly idle
        idle_pct  = 76;
        stall_pct = 0;
        queue_random_work(340);
        wait_drained();

        // receiver mostly stalling
        idle_pct  = 0;
        stall_pct = 76;
        queue_random_work(340);
        wait_drained();

        // both sides idling now and then
        idle_pct  = 20;
        stall_pct = 20;
        queue_random_work(340);
        wait_drained();

        repeat (TAIL_LEN) @(negedge clk);
        if (rsp_expect_q.size() != 0)
            flag_mismatch($sformatf("%0d responses never arrived", rsp_expect_q.size()));

        $display("tb: %0d commands, %0d ticks, %0d channel expiries, %0d rejected",
                 n_cmds, n_ticks, n_expired, n_rejected);
        $display("tb: idle/stall mixes and a long response hold-off, %0d mismatches",
                 n_fail);
        if (n_fail == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
